// ===== design/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg: shared definitions for the priority scheduler
// Table depth, field widths, operation codes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Table geometry.
  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENTRIES - 1);

  // Field widths.
  localparam int PIDX_W = 4;
  localparam int WORK_W = 16;
  localparam int PRIO_W = 7;
  localparam int TIME_W = 24;
  localparam int WAIT_W = 25;

  localparam logic [PRIO_W-1:0] CEILING_RESET = PRIO_W'(101);
  localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};

  // Operation codes.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESTART,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic tick_start;
    logic scan_step;
    logic restart_start;
    logic restart_step;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: preemptive priority scheduler, top level
// Joins the scheduler controller and datapath.
// ----------------------------------------------------------------------------
// A load word writes one table entry. A restart word restores the remaining
// counts from the burst lengths, one entry per cycle. A tick word runs the
// serial minimum search through the single eligibility compare and then
// commits the result once the output register is free of a previous result
// that still waits on out_ready. The result sits in an output register, so
// the next word is accepted while it waits. Only tick words produce a result.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic [PIDX_W-1:0]        in_process_index,
  input  logic [WORK_W-1:0]        in_burst,
  input  logic [WORK_W-1:0]        in_arrival,
  input  logic [PRIO_W-1:0]        in_priority_req,
  input  logic                     cfg_we,
  input  logic [PRIO_W-1:0]        cfg_wdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TIME_W-1:0]        out_slot_time,
  output logic                     out_idle,
  output logic [PIDX_W-1:0]        out_chosen_index,
  output logic                     out_finished,
  output logic signed [WAIT_W-1:0] out_waiting,
  output logic [TIME_W-1:0]        out_turnaround
);

  cmd_t cmd;
  sts_t sts;

  // Controller.
  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  pss_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_process_index (in_process_index),
    .in_burst         (in_burst),
    .in_arrival       (in_arrival),
    .in_priority_req  (in_priority_req),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_slot_time    (out_slot_time),
    .out_idle         (out_idle),
    .out_chosen_index (out_chosen_index),
    .out_finished     (out_finished),
    .out_waiting      (out_waiting),
    .out_turnaround   (out_turnaround)
  );

endmodule

// ===== design/pss_ctrl.sv =====
// ----------------------------------------------------------------------------
// pss_ctrl: scheduler controller
// Decodes accepted words and sequences the table scan, the restart sweep and
// the result commit.
// ----------------------------------------------------------------------------
module pss_ctrl
  import pss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_opcode)
            OP_LOAD: begin
              cmd.load = 1'b1;
            end
            OP_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = S_SCAN;
            end
            OP_RESTART: begin
              cmd.restart_start = 1'b1;
              state_nxt         = S_RESTART;
            end
            default: begin
              // Unused code: the word is dropped.
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_DONE;
        end
      end
      S_RESTART: begin
        cmd.restart_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pss_dp.sv =====
// ----------------------------------------------------------------------------
// pss_dp: scheduler datapath
// Holds the process table, time counter and ceiling register, runs the
// serial minimum search and drives the result register.
// ----------------------------------------------------------------------------
module pss_dp
  import pss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [PIDX_W-1:0]        in_process_index,
  input  logic [WORK_W-1:0]        in_burst,
  input  logic [WORK_W-1:0]        in_arrival,
  input  logic [PRIO_W-1:0]        in_priority_req,
  input  logic                     cfg_we,
  input  logic [PRIO_W-1:0]        cfg_wdata,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [TIME_W-1:0]        out_slot_time,
  output logic                     out_idle,
  output logic [PIDX_W-1:0]        out_chosen_index,
  output logic                     out_finished,
  output logic signed [WAIT_W-1:0] out_waiting,
  output logic [TIME_W-1:0]        out_turnaround
);

  // Process table.
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [WORK_W-1:0]      burst_r     [NUM_ENTRIES];
  logic [WORK_W-1:0]      arrival_r   [NUM_ENTRIES];
  logic [PRIO_W-1:0]      prio_r      [NUM_ENTRIES];
  logic [WORK_W-1:0]      remaining_r [NUM_ENTRIES];

  logic [TIME_W-1:0] time_r;
  logic [PRIO_W-1:0] ceiling_r;
  logic [IDX_W-1:0]  cnt_r;

  // Best candidate so far.
  logic [PRIO_W-1:0] best_r;
  logic              found_r;
  logic [IDX_W-1:0]  pick_r;
  logic [WORK_W-1:0] pick_arr_r;
  logic [WORK_W-1:0] pick_burst_r;
  logic [WORK_W-1:0] pick_rem_r;

  logic              out_valid_r;
  logic [TIME_W-1:0] slot_time_r;
  logic              idle_r;
  logic [PIDX_W-1:0] chosen_r;
  logic              finished_r;
  logic [WAIT_W-1:0] waiting_r;
  logic [TIME_W-1:0] turnaround_r;

  logic              load_hit;
  logic [IDX_W-1:0]  load_idx;
  logic              eligible;
  logic [TIME_W-1:0] time_after;

  assign load_hit = (int'(in_process_index) < NUM_ENTRIES);
  assign load_idx = IDX_W'(in_process_index);

  // Eligibility of the entry under the scan pointer.
  assign eligible = valid_r[cnt_r] && (remaining_r[cnt_r] != '0) &&
                    (TIME_W'(arrival_r[cnt_r]) <= time_r) &&
                    (prio_r[cnt_r] < best_r);

  assign time_after = (time_r == TIME_MAX) ? TIME_MAX : time_r + TIME_W'(1);

  assign sts.cnt_last = (cnt_r == IDX_LAST);
  assign sts.out_free = !out_valid_r || out_ready;

  // Control registers: valid bits, time, ceiling, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      time_r      <= '0;
      ceiling_r   <= CEILING_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && load_hit) begin
        valid_r[load_idx] <= 1'b1;
      end
      if (cmd.restart_start) begin
        time_r <= '0;
      end else if (cmd.commit) begin
        time_r <= time_after;
      end
      if (cfg_we) begin
        ceiling_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Table payload: load, restart sweep and decrement of the picked entry.
  always_ff @(posedge clk) begin
    if (cmd.load && load_hit) begin
      burst_r[load_idx]     <= in_burst;
      arrival_r[load_idx]   <= in_arrival;
      prio_r[load_idx]      <= in_priority_req;
      remaining_r[load_idx] <= in_burst;
    end
    if (cmd.restart_step) begin
      remaining_r[cnt_r] <= burst_r[cnt_r];
    end
    if (cmd.commit && found_r) begin
      remaining_r[pick_r] <= pick_rem_r - WORK_W'(1);
    end
  end

  // Scan pointer and running minimum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.tick_start || cmd.restart_start) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step || cmd.restart_step) begin
      cnt_r <= sts.cnt_last ? '0 : cnt_r + IDX_W'(1);
      if (cmd.scan_step && eligible) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      best_r <= ceiling_r;
      pick_r <= '0;
    end else if (cmd.scan_step && eligible) begin
      best_r       <= prio_r[cnt_r];
      pick_r       <= cnt_r;
      pick_arr_r   <= arrival_r[cnt_r];
      pick_burst_r <= burst_r[cnt_r];
      pick_rem_r   <= remaining_r[cnt_r];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_time_r <= time_r;
      idle_r      <= !found_r;
      if (found_r) begin
        chosen_r     <= PIDX_W'(pick_r);
        finished_r   <= (pick_rem_r == WORK_W'(1));
        waiting_r    <= WAIT_W'(time_after) - WAIT_W'(pick_arr_r) - WAIT_W'(pick_burst_r);
        turnaround_r <= time_after - TIME_W'(pick_arr_r);
      end else begin
        chosen_r     <= '0;
        finished_r   <= 1'b0;
        waiting_r    <= '0;
        turnaround_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_time    = slot_time_r;
  assign out_idle         = idle_r;
  assign out_chosen_index = chosen_r;
  assign out_finished     = finished_r;
  assign out_waiting      = signed'(waiting_r);
  assign out_turnaround   = turnaround_r;

  // A commit never overwrites a word that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over a pending word");

  // A commit always presents a word in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  // An idle result carries no entry information.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && idle_r) |-> (chosen_r == '0 && !finished_r && turnaround_r == '0))
    else $error("idle result with nonzero fields");

  // Time only moves backward on a restart.
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.restart_start |=> (time_r >= $past(time_r)))
    else $error("time counter decreased without restart");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the preemptive priority scheduler
// A directed table of words runs first. Then phases of random load, tick,
// restart and unused-code words run under several priority ceilings. An
// in-bench scheduler model predicts each tick result, and a monitor checks
// every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import pss_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_WORDS = 122;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_FROM   = 420;
  localparam int CALM_TO     = 540;
  localparam int SETTLE      = NUM_ENTRIES + 6;

  // One input word and one result word.
  typedef struct packed {
    logic [1:0]        opcode;
    logic [PIDX_W-1:0] pidx;
    logic [WORK_W-1:0] burst;
    logic [WORK_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
  } word_t;

  typedef struct packed {
    logic [TIME_W-1:0]        slot_time;
    logic                     idle;
    logic [PIDX_W-1:0]        chosen;
    logic                     finished;
    logic signed [WAIT_W-1:0] waiting;
    logic [TIME_W-1:0]        turnaround;
  } slot_res_t;

  typedef struct {
    word_t     w;
    bit        typed;
    slot_res_t res;
  } dir_row_t;

  localparam slot_res_t NO_RES = '0;

  // Directed words; results are typed in where they are obvious by hand.
  dir_row_t dir_tbl [21] = '{
    // Empty table: idle ticks at times 0 and 1.
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b1, '{24'd0, 1'b1, 4'd0, 1'b0, 25'sd0, 24'd0}},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b1, '{24'd1, 1'b1, 4'd0, 1'b0, 25'sd0, 24'd0}},
    '{'{OP_RESTART, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES},
    // Priority just below the ceiling, never arriving, zero burst, at ceiling.
    '{'{OP_LOAD, 4'd0, 16'd2, 16'd0, 7'd100}, 1'b0, NO_RES},
    '{'{OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 7'd0}, 1'b0, NO_RES},
    '{'{OP_LOAD, 4'd3, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES},
    '{'{OP_LOAD, 4'd5, 16'd1, 16'd0, 7'd101}, 1'b0, NO_RES},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b1,
      '{24'd0, 1'b0, 4'd0, 1'b0, -25'sd1, 24'd1}},
    // The unused opcode is dropped without a result.
    '{'{OP_UNUSED, 4'd7, 16'hFFFF, 16'hFFFF, 7'd127}, 1'b0, NO_RES},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b1, '{24'd1, 1'b0, 4'd0, 1'b1, 25'sd0, 24'd2}},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b1, '{24'd2, 1'b1, 4'd0, 1'b0, 25'sd0, 24'd0}},
    // Equal priorities tie toward the lower index, then a preemption.
    '{'{OP_LOAD, 4'd8, 16'd3, 16'd2, 7'd50}, 1'b0, NO_RES},
    '{'{OP_LOAD, 4'd9, 16'd2, 16'd0, 7'd50}, 1'b0, NO_RES},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES},
    '{'{OP_LOAD, 4'd2, 16'd1, 16'd3, 7'd10}, 1'b0, NO_RES},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES},
    // Restart brings back all work and time zero.
    '{'{OP_RESTART, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES},
    '{'{OP_LOAD, 4'd15, 16'hFFFF, 16'd0, 7'd0}, 1'b0, NO_RES},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 7'd0}, 1'b0, NO_RES}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_opcode = OP_LOAD;
  logic [PIDX_W-1:0]        in_process_index = '0;
  logic [WORK_W-1:0]        in_burst = '0;
  logic [WORK_W-1:0]        in_arrival = '0;
  logic [PRIO_W-1:0]        in_priority_req = '0;
  logic                     cfg_we = 1'b0;
  logic [PRIO_W-1:0]        cfg_wdata = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [TIME_W-1:0]        out_slot_time;
  logic                     out_idle;
  logic [PIDX_W-1:0]        out_chosen_index;
  logic                     out_finished;
  logic signed [WAIT_W-1:0] out_waiting;
  logic [TIME_W-1:0]        out_turnaround;

  // Scheduler model state.
  bit                tbl_valid [NUM_ENTRIES];
  logic [WORK_W-1:0] tbl_burst [NUM_ENTRIES];
  logic [WORK_W-1:0] tbl_arr   [NUM_ENTRIES];
  logic [PRIO_W-1:0] tbl_prio  [NUM_ENTRIES];
  logic [WORK_W-1:0] tbl_left  [NUM_ENTRIES];
  logic [TIME_W-1:0] time_m = '0;
  logic [PRIO_W-1:0] ceiling_m = CEILING_RESET;

  slot_res_t slot_q [$];
  int        err_cnt = 0;
  int        words_sent = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;

  preemptive_priority_scheduler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_process_index (in_process_index),
    .in_burst         (in_burst),
    .in_arrival       (in_arrival),
    .in_priority_req  (in_priority_req),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_time    (out_slot_time),
    .out_idle         (out_idle),
    .out_chosen_index (out_chosen_index),
    .out_finished     (out_finished),
    .out_waiting      (out_waiting),
    .out_turnaround   (out_turnaround)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // Apply one word to the model; returns 1 when the word yields a slot result.
  function automatic bit schedule_word(input word_t w, output slot_res_t r);
    logic [TIME_W-1:0] after;
    logic [PRIO_W-1:0] best;
    int pick;
    int wait_i;
    r = '0;
    case (w.opcode)
      OP_LOAD: begin
        tbl_valid[w.pidx] = 1'b1;
        tbl_burst[w.pidx] = w.burst;
        tbl_arr[w.pidx]   = w.arrival;
        tbl_prio[w.pidx]  = w.prio;
        tbl_left[w.pidx]  = w.burst;
        return 1'b0;
      end
      OP_RESTART: begin
        for (int i = 0; i < NUM_ENTRIES; i++) tbl_left[i] = tbl_burst[i];
        time_m = '0;
        return 1'b0;
      end
      OP_TICK: begin
        after = (time_m == TIME_MAX) ? TIME_MAX : time_m + 1'b1;
        best  = ceiling_m;
        pick  = -1;
        // Strict compare keeps the lowest index among equal priorities.
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_left[i] != 0 && tbl_arr[i] <= time_m &&
              tbl_prio[i] < best) begin
            best = tbl_prio[i];
            pick = i;
          end
        end
        r.slot_time = time_m;
        r.idle      = (pick < 0);
        if (pick >= 0) begin
          tbl_left[pick] = tbl_left[pick] - 1'b1;
          wait_i = int'(after) - int'(tbl_arr[pick]) - int'(tbl_burst[pick]);
          r.chosen     = pick[PIDX_W-1:0];
          r.finished   = (tbl_left[pick] == 0);
          r.waiting    = WAIT_W'(wait_i);
          r.turnaround = after - TIME_W'(tbl_arr[pick]);
        end
        time_m = after;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offer one word, hold it until accepted, then record its expected result.
  task automatic push_word(input word_t w, input bit typed, input slot_res_t typed_res);
    slot_res_t r;
    bit has_res;
    if (!calm) begin
      while ($urandom_range(0, 99) < 16) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_opcode        <= w.opcode;
    in_process_index <= w.pidx;
    in_burst         <= w.burst;
    in_arrival       <= w.arrival;
    in_priority_req  <= w.prio;
    do @(posedge clk); while (!in_ready);
    has_res = schedule_word(w, r);
    if (has_res) slot_q.push_back(typed ? typed_res : r);
    words_sent++;
    if (words_sent == HOLD_AT) hold_req = 1'b1;
    calm = (words_sent >= CALM_FROM && words_sent < CALM_TO);
  endtask

  // Let every pending result out and give a running restart time to finish.
  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (slot_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_ceiling(input logic [PRIO_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ceiling_m = v;
  endtask

  // Result side: random back-pressure plus one long hold-off.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin : slot_check
    slot_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (slot_q.size() == 0) begin
        $display("%0t: unexpected result word, slot_time %0d", $time, out_slot_time);
        err_cnt++;
      end else begin
        e = slot_q.pop_front();
        if (out_slot_time !== e.slot_time) begin
          $display("%0t: slot_time expected %0d actual %0d", $time, e.slot_time,
                   out_slot_time);
          err_cnt++;
        end
        if (out_idle !== e.idle) begin
          $display("%0t: idle expected %0d actual %0d", $time, e.idle, out_idle);
          err_cnt++;
        end
        if (out_chosen_index !== e.chosen) begin
          $display("%0t: chosen_index expected %0d actual %0d", $time, e.chosen,
                   out_chosen_index);
          err_cnt++;
        end
        if (out_finished !== e.finished) begin
          $display("%0t: finished expected %0d actual %0d", $time, e.finished,
                   out_finished);
          err_cnt++;
        end
        if (out_waiting !== e.waiting) begin
          $display("%0t: waiting expected %0d actual %0d", $time, e.waiting, out_waiting);
          err_cnt++;
        end
        if (out_turnaround !== e.turnaround) begin
          $display("%0t: turnaround expected %0d actual %0d", $time, e.turnaround,
                   out_turnaround);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin : stimulus
    word_t w;
    int sel;
    for (int i = 0; i < NUM_ENTRIES; i++) tbl_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) push_word(dir_tbl[i].w, dir_tbl[i].typed, dir_tbl[i].res);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Ceiling changes only with the scheduler quiet.
      if (ph != 0) begin
        drain_words();
        case (ph)
          1:       set_ceiling(7'd127);
          2:       set_ceiling(7'd0);
          4:       set_ceiling(7'd1);
          default: set_ceiling(PRIO_W'($urandom_range(2, 126)));
        endcase
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w = word_t'({$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 28) begin
          // Mostly short bursts that arrive soon, so ticks have real work.
          w.opcode = OP_LOAD;
          case ($urandom_range(0, 9))
            0:       w.burst = '0;
            1:       w.burst = WORK_W'($urandom);
            default: w.burst = WORK_W'($urandom_range(1, 12));
          endcase
          if ($urandom_range(0, 9) != 0) w.arrival = WORK_W'($urandom_range(0, 40));
        end else if (sel < 90) begin
          w.opcode = OP_TICK;
        end else if (sel < 96) begin
          w.opcode = OP_RESTART;
        end else begin
          w.opcode = OP_UNUSED;
        end
        push_word(w, 1'b0, NO_RES);
      end
    end

    drain_words();
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
